>>> rtl/core/timer_slot_table_defines.svh
// Assertion macros used by the timer slot table checker.
`ifndef TIMER_SLOT_TABLE_DEFINES_SVH
`define TIMER_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer slot table check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer slot table check failed");

`endif

>>> rtl/core/tst_pkg.sv
// Shared constants, types and control bundle of the timer slot table.
package tst_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DELAY_W = 16;
	localparam int TAG_W = 32;
	localparam int DEL_W = 8;
	localparam int IDX_W = 9;
	localparam int TIME_W = 32;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 64;
	localparam logic [15:0] WAIT_MAX = 16'hFFFF;
	localparam logic [TIME_W-1:0] DUE_WINDOW_MS = 32'd1;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_DEL  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_SLOT = 2'd2,
		ST_NOTHING  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIRE,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              accept;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              fire;
		logic              load_out;
	} ctrl_cmd_t;

endpackage

>>> rtl/core/tst_ctrl.sv
// Controller state machine of the timer slot table: sequencing and handshakes.
module tst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output tst_pkg::ctrl_cmd_t cmd
);
	import tst_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic [SLOT_W-1:0] scan_cnt_q;
	logic m_valid_q;
	logic scan_last;

	assign scan_last = (scan_cnt_q == SLOT_W'(SLOTS - 1));
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (scan_last) state_nxt = S_DRAIN;
			end
			S_DRAIN: state_nxt = S_FIRE;
			S_FIRE:  state_nxt = S_OUT;
			S_OUT: begin
				if (!m_valid_q || m_tready) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == S_IDLE);
		cmd.accept = s_tready && s_tvalid;
		cmd.rd_en = (state_q == S_SCAN);
		cmd.rd_addr = scan_cnt_q;
		cmd.fire = (state_q == S_FIRE);
		cmd.load_out = (state_q == S_OUT) && (!m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) scan_cnt_q <= '0;
			else if (cmd.rd_en && !scan_last) scan_cnt_q <= scan_cnt_q + 1'b1;
			if (cmd.load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/core/tst_dpath.sv
// Datapath of the timer slot table: slot stores, time counter, scan and result.
module tst_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tst_pkg::ctrl_cmd_t                cmd,
	input  logic [tst_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [1:0]                        s_tuser,
	output logic [tst_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [2:0]                        m_tuser
);
	import tst_pkg::*;

	logic [SLOTS-1:0] valid_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] dl_mem [SLOTS];
	logic [TAG_W-1:0] tag_mem [SLOTS];

	// Fields of the accepted transaction.
	cmd_t in_cmd;
	logic [DELAY_W-1:0] in_delay;
	logic [TAG_W-1:0] in_tag;
	logic [DEL_W-1:0] in_slot;
	logic del_ok;

	cmd_t cmd_q;
	status_t res_status_q;
	logic [IDX_W-1:0] res_index_q;

	logic [SLOT_W-1:0] free_idx;
	logic any_free;

	// Scan stage.
	logic rd_vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic vbit_s1;
	logic [TIME_W-1:0] dl_s1;
	logic [TIME_W-1:0] diff;
	logic due;
	logic [15:0] wait_val;
	logic found_q;
	logic [SLOT_W-1:0] fire_idx_q;
	logic [15:0] min_q;
	logic [TAG_W-1:0] tag_rd_q;

	// Output register payload.
	status_t out_status_q;
	logic [IDX_W-1:0] out_index_q;
	logic out_fired_q;
	logic [TAG_W-1:0] out_tag_q;
	logic [15:0] out_wait_q;

	assign in_cmd = cmd_t'(s_tuser);
	assign in_delay = s_tdata[15:0];
	assign in_tag = s_tdata[47:16];
	assign in_slot = s_tdata[55:48];
	assign del_ok = ({1'b0, in_slot} < IDX_W'(SLOTS));

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = SLOT_W'(i);
		end
		any_free = ~&valid_q;
	end

	always_comb begin
		diff = dl_s1 - now_q;
		due = diff[TIME_W-1] || (diff <= DUE_WINDOW_MS);
		if (diff[TIME_W-1]) wait_val = '0;
		else if (|diff[TIME_W-1:16]) wait_val = WAIT_MAX;
		else wait_val = diff[15:0];
	end

	// Control state: valid bits, time, scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			now_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.accept) begin
				found_q <= 1'b0;
				case (in_cmd)
					CMD_TICK: now_q <= now_q + 1'b1;
					CMD_ADD: begin
						if (any_free) valid_q[free_idx] <= 1'b1;
					end
					CMD_DEL: begin
						if (del_ok) valid_q[in_slot[SLOT_W-1:0]] <= 1'b0;
					end
					default: ;
				endcase
			end else if (cmd.fire) begin
				if (found_q) valid_q[fire_idx_q] <= 1'b0;
			end else if (rd_vld_s1 && vbit_s1 && cmd_q == CMD_TICK && due && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= in_cmd;
			min_q <= WAIT_MAX;
			case (in_cmd)
				CMD_ADD: begin
					res_status_q <= any_free ? ST_OK : ST_FULL;
					res_index_q <= any_free ? IDX_W'(free_idx) : IDX_W'(SLOTS);
				end
				CMD_DEL: begin
					res_status_q <= del_ok ? ST_OK : ST_BAD_SLOT;
					res_index_q <= del_ok ? IDX_W'(in_slot) : IDX_W'(SLOTS);
				end
				default: begin
					res_status_q <= ST_NOTHING;
					res_index_q <= IDX_W'(SLOTS);
				end
			endcase
		end else if (rd_vld_s1 && vbit_s1) begin
			// The first due slot on a tick is freed, so it stays out of the minimum.
			if (cmd_q == CMD_TICK && due && !found_q) fire_idx_q <= idx_s1;
			else if (wait_val < min_q) min_q <= wait_val;
		end
		if (cmd.rd_en) begin
			idx_s1 <= cmd.rd_addr;
			vbit_s1 <= valid_q[cmd.rd_addr];
		end
		if (cmd.load_out) begin
			out_status_q <= found_q ? ST_OK : res_status_q;
			out_index_q <= found_q ? IDX_W'(fire_idx_q) : res_index_q;
			out_fired_q <= found_q;
			out_tag_q <= found_q ? tag_rd_q : '0;
			out_wait_q <= min_q;
		end
	end

	// Slot stores.
	always_ff @(posedge clk) begin
		if (cmd.accept && in_cmd == CMD_ADD && any_free) begin
			dl_mem[free_idx] <= now_q + TIME_W'(in_delay);
			tag_mem[free_idx] <= in_tag;
		end
		if (cmd.rd_en) dl_s1 <= dl_mem[cmd.rd_addr];
		if (cmd.fire) tag_rd_q <= tag_mem[fire_idx_q];
	end

	assign m_tdata = {7'd0, out_wait_q, out_tag_q, out_index_q};
	assign m_tuser = {out_fired_q, out_status_q};

endmodule

>>> rtl/core/timer_slot_table.sv
// Top level of the timer slot table: controller and datapath joined.
// The block keeps SLOTS one-shot millisecond timers. Each input transaction
// carries a command in s_tuser: tick advances the millisecond clock by one and
// fires the lowest-numbered pending slot whose deadline is at most one ms
// ahead or already passed; add claims the lowest free slot with deadline
// now plus delay_ms and keeps the tag; delete frees a slot by index. Every
// command yields exactly one result transaction with status, slot index, the
// fired flag and tag, and the ms left to the earliest pending deadline after
// the command took effect (65535 when none is pending or the gap is larger).
// After an item is accepted, the accepting cycle applies the command, the
// slots are then stepped through one after another on the single
// deadline-memory read port, the read stage is drained, the fired tag is
// fetched and the output register is loaded, in that order. A new
// transaction is accepted once the result has moved into the output
// register, even while the downstream side still holds it off; that
// next item then waits in its last step until the held result is taken.
// There is no clearing pass after reset; slot contents are guarded by valid
// bits cleared at reset.
module timer_slot_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] delay_ms, [47:16] tag, [55:48] slot
	input  logic [tst_pkg::IN_DATA_W-1:0]       s_tdata,
	// [1:0] command
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [8:0] slot_index, [40:9] fired_tag, [56:41] wait_ms, [63:57] zero
	output logic [tst_pkg::OUT_DATA_W-1:0]      m_tdata,
	// [1:0] status, [2] fired
	output logic [2:0]                          m_tuser
);
	import tst_pkg::*;

	ctrl_cmd_t cmd;

	// Sequencer: accepts a transaction, walks the slots, hands off the result.
	tst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Slot stores, time counter, scan arithmetic and the output register.
	tst_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

>>> rtl/core/tst_checker.sv
// Port-level assertions of the timer slot table and their binding.
`include "timer_slot_table_defines.svh"

module tst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [tst_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic [2:0]                        m_tuser
);
	import tst_pkg::*;

	// A stalled result keeps its payload.
	`TST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// Only one item is worked on at a time.
	`TST_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	// A fired timer always reports success.
	`TST_ASSERT_NOW(a_fired_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_OK)
	// Without a fire the tag field is zero.
	`TST_ASSERT_NOW(a_tag_zero, m_tvalid && !m_tuser[2], m_tdata[40:9] == '0)
	// Any failure status carries the no-slot index.
	`TST_ASSERT_NOW(a_fail_index, m_tvalid && m_tuser[1:0] != ST_OK, m_tdata[8:0] == IDX_W'(SLOTS))

endmodule

bind timer_slot_table tst_checker u_tst_checker (.*);
